// ----- design/rhsl_pkg.sv -----
// rhsl_pkg: shared types and constants for the rgb to hsl pixel converter
// no dependencies; imported by every module of the block
`default_nettype none

package rhsl_pkg;

    localparam int CH_W    = 8;
    localparam int OUT_W   = 16;
    localparam int SUM_W   = 9;
    localparam int DEN_W   = 9;
    localparam int NUM_W   = 11;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [SUM_W-1:0] HALF_SPAN = 9'd255;
    localparam logic [SUM_W-1:0] FULL_SPAN = 9'd510;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] saturation;
        logic [CH_W-1:0]  lightness;
    } t_hsl;

    // classified pixel handed from front end to divider pipeline
    typedef struct packed {
        logic             gray;
        logic             sat_int;
        logic [DEN_W-1:0] sat_rem;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] hue_rem;
        logic [NUM_W-1:0] six_d;
        logic [CH_W-1:0]  light;
    } t_cls;

endpackage

`default_nettype wire

// ----- design/rgb_to_hsl_pixel.sv -----
// rgb_to_hsl_pixel: top level of the rgb to hsl pixel converter
// depends on rhsl_pkg, rhsl_front, rhsl_queue and rhsl_div_pipe
//
// input channel: a pixel on i_pixel is transferred at a rising edge where
// start is high and busy is low. the front end finds max and min, lightness
// and the divider operands, and posts them to a two-entry queue.
// output channel: each result sits on o_hsl for exactly one cycle with
// o_valid high; the receiver takes it in that cycle and cannot hold it off.
// path: a pixel passes the front end register, a queue slot, the divider
// stages and the output register, in that order, before o_valid rises.
// throughput: one pixel per clock. the divider pipeline takes one quotient
// bit of hue and of saturation per stage, FRAC_BITS stages, and takes the
// queue head every cycle, so busy stays low in steady operation.
// results come out in transfer order, one per pixel.
// reset (synchronous, active low) empties the queue and the pipeline and
// drops any pixel in flight; no results appear until new pixels arrive.
`default_nettype none

module rgb_to_hsl_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rhsl_pkg::t_rgb  i_pixel,
    output logic            o_valid,
    output rhsl_pkg::t_hsl  o_hsl
);
    import rhsl_pkg::*;

    logic full;
    logic push;
    logic q_valid;
    t_cls f_cls;
    t_cls q_cls;

    rhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pixel (i_pixel),
        .i_full  (full),
        .o_busy  (busy),
        .o_push  (push),
        .o_cls   (f_cls)
    );

    rhsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (f_cls),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cls   (q_cls)
    );

    rhsl_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_valid (o_valid),
        .o_hsl   (o_hsl)
    );

endmodule

`default_nettype wire

// ----- design/rhsl_front.sv -----
// rhsl_front: accepts pixels, finds max/min and forms the divider operands
// depends on rhsl_pkg
`default_nettype none

module rhsl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rhsl_pkg::t_rgb  i_pixel,
    input  logic            i_full,
    output logic            o_busy,
    output logic            o_push,
    output rhsl_pkg::t_cls  o_cls
);
    import rhsl_pkg::*;

    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic [CH_W-1:0]   d;
    logic [SUM_W-1:0]  sum;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  six_d;
    logic signed [11:0] num_s;
    logic              accept;
    logic              n_fv;
    logic              r_fv;
    t_cls              n_cls;
    t_cls              r_cls;

    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue > mx) mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue < mn) mn = i_pixel.blue;
        d     = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        den   = (sum < HALF_SPAN) ? sum : FULL_SPAN - sum;
        six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};

        // hue numerator in sixths of a turn over delta
        if (i_pixel.red == mx) begin
            num_s = $signed({4'b0, i_pixel.green}) - $signed({4'b0, i_pixel.blue});
        end else if (i_pixel.green == mx) begin
            num_s = $signed({3'b0, d, 1'b0}) + $signed({4'b0, i_pixel.blue})
                  - $signed({4'b0, i_pixel.red});
        end else begin
            num_s = $signed({2'b0, d, 2'b0}) + $signed({4'b0, i_pixel.red})
                  - $signed({4'b0, i_pixel.green});
        end
        if (num_s < 0) begin
            num_s = num_s + $signed({1'b0, six_d});
        end

        n_cls.gray    = (d == '0);
        n_cls.sat_int = ({1'b0, d} >= den);
        n_cls.sat_rem = n_cls.sat_int ? {1'b0, d} - den : {1'b0, d};
        n_cls.den     = den;
        n_cls.hue_rem = num_s[NUM_W-1:0];
        n_cls.six_d   = six_d;
        n_cls.light   = sum[SUM_W-1:1];
    end

    assign o_busy = r_fv & i_full;
    assign accept = i_start & ~o_busy;
    assign n_fv   = accept | (r_fv & i_full);
    assign o_push = r_fv & ~i_full;
    assign o_cls  = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

// ----- design/rhsl_queue.sv -----
// rhsl_queue: two-entry queue between front end and divider pipeline
// depends on rhsl_pkg; the pipeline takes the head every cycle it is present
`default_nettype none

module rhsl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rhsl_pkg::t_cls  i_cls,
    output logic            o_full,
    output logic            o_valid,
    output rhsl_pkg::t_cls  o_cls
);
    import rhsl_pkg::*;

    t_cls              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_cnt;
    logic              pop;

    assign pop     = (r_cnt != '0);
    assign o_valid = pop;
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_cls   = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt + {{(QCNT_W-1){1'b0}}, i_push} - {{(QCNT_W-1){1'b0}}, pop};
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cls;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count not raised on lone push");

endmodule

`default_nettype wire

// ----- design/rhsl_div_pipe.sv -----
// rhsl_div_pipe: pipelined restoring dividers for saturation and hue
// depends on rhsl_pkg; one quotient bit of each per stage, then output register
`default_nettype none

module rhsl_div_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rhsl_pkg::t_cls  i_cls,
    output logic            o_valid,
    output rhsl_pkg::t_hsl  o_hsl
);
    import rhsl_pkg::*;

    typedef struct packed {
        logic                 gray;
        logic                 sat_int;
        logic [DEN_W-1:0]     sat_rem;
        logic [DEN_W-1:0]     den;
        logic [NUM_W-1:0]     hue_rem;
        logic [NUM_W-1:0]     six_d;
        logic [FRAC_BITS-1:0] sat_q;
        logic [FRAC_BITS-1:0] hue_q;
        logic [CH_W-1:0]      light;
    } t_stage;

    t_stage                       s_in;
    t_stage                       r_st [FRAC_BITS];
    logic [FRAC_BITS-1:0]         r_v;
    t_stage                       last;
    logic [FRAC_BITS+OUT_W-1:0]   hue_w;
    logic [FRAC_BITS+OUT_W-1:0]   sat_w;
    t_hsl                         n_out;
    t_hsl                         r_out;
    logic                         r_ov;

    always_comb begin
        s_in.gray    = i_cls.gray;
        s_in.sat_int = i_cls.sat_int;
        s_in.sat_rem = i_cls.sat_rem;
        s_in.den     = i_cls.den;
        s_in.hue_rem = i_cls.hue_rem;
        s_in.six_d   = i_cls.six_d;
        s_in.sat_q   = '0;
        s_in.hue_q   = '0;
        s_in.light   = i_cls.light;
    end

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
        t_stage           w_prev;
        t_stage           w_next;
        logic             w_vprev;
        logic [DEN_W:0]   sh_s;
        logic [NUM_W:0]   sh_h;
        logic             ge_s;
        logic             ge_h;

        if (i == 0) begin : g_first
            assign w_prev  = s_in;
            assign w_vprev = i_valid;
        end else begin : g_rest
            assign w_prev  = r_st[i-1];
            assign w_vprev = r_v[i-1];
        end

        always_comb begin
            sh_s   = {w_prev.sat_rem, 1'b0};
            sh_h   = {w_prev.hue_rem, 1'b0};
            ge_s   = (sh_s >= {1'b0, w_prev.den});
            ge_h   = (sh_h >= {1'b0, w_prev.six_d});
            w_next = w_prev;
            w_next.sat_rem = ge_s ? DEN_W'(sh_s - {1'b0, w_prev.den}) : sh_s[DEN_W-1:0];
            w_next.hue_rem = ge_h ? NUM_W'(sh_h - {1'b0, w_prev.six_d}) : sh_h[NUM_W-1:0];
            w_next.sat_q   = {w_prev.sat_q[FRAC_BITS-2:0], ge_s};
            w_next.hue_q   = {w_prev.hue_q[FRAC_BITS-2:0], ge_h};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= w_vprev;
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[i] <= w_next;
        end
    end

    assign last = r_st[FRAC_BITS-1];

    always_comb begin
        hue_w = {{OUT_W{1'b0}}, last.hue_q};
        sat_w = {{OUT_W{1'b0}}, (last.sat_int ? {FRAC_BITS{1'b1}} : last.sat_q)};
        n_out.hue        = last.gray ? '0 : hue_w[OUT_W-1:0];
        n_out.saturation = last.gray ? '0 : sat_w[OUT_W-1:0];
        n_out.lightness  = last.light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[FRAC_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_hsl   = r_out;

    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[FRAC_BITS-1] && !last.gray |-> last.hue_rem < last.six_d)
        else $error("hue remainder not below divisor");

    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[FRAC_BITS-1] && !last.gray |-> last.sat_rem < last.den)
        else $error("saturation remainder not below divisor");

    a_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.lightness == {CH_W{1'b1}} |->
            r_out.hue == '0 && r_out.saturation == '0)
        else $error("white pixel with nonzero hue or saturation");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for rgb_to_hsl_pixel, directed and random pixels
// checks every hue, saturation and lightness against an in-bench integer model
// depends on rhsl_pkg and rgb_to_hsl_pixel

module tb_top;

    import rhsl_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 50;
    localparam int IDLE_PCT    = 32;
    localparam int LIGHT_MID   = 255;
    localparam int LIGHT_SPAN  = 510;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_rgb  i_pixel;
    logic  o_valid;
    t_hsl  o_hsl;

    t_hsl  expected_hsl[$];
    int    error_count;
    int    stall_cycles;

    rgb_to_hsl_pixel #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_pixel(i_pixel),
        .o_valid(o_valid),
        .o_hsl  (o_hsl)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // integer hsl conversion, quotients floored
    function automatic t_hsl hsl_of(input t_rgb px);
        int unsigned       r, g, b, mx, mn, d, sum, den, six_d;
        int                num;
        longint unsigned   one, q;
        t_hsl              res;
        r     = px.red;
        g     = px.green;
        b     = px.blue;
        one   = longint'(1) << FRAC_BITS;
        mx    = r;
        mn    = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d     = mx - mn;
        sum   = mx + mn;
        res   = '0;
        res.lightness = CH_W'(sum >> 1);
        if (d != 0) begin
            den   = (sum < LIGHT_MID) ? sum : LIGHT_SPAN - sum;
            six_d = 6 * d;
            if (den != 0) begin
                q = (longint'(d) << FRAC_BITS) / den;
                if (q >= one) q = one - 1;
                res.saturation = q[OUT_W-1:0];
            end
            if (r == mx)
                num = int'(g) - int'(b);
            else if (g == mx)
                num = 2 * int'(d) + (int'(b) - int'(r));
            else
                num = 4 * int'(d) + (int'(r) - int'(g));
            if (num < 0) num += int'(six_d);
            q = (longint'(num) << FRAC_BITS) / six_d;
            q = q & (one - 1);
            res.hue = q[OUT_W-1:0];
        end
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_hsl exp_res;
        if (i_rst_n && o_valid) begin
            if (expected_hsl.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result hue %0d sat %0d light %0d", $time,
                             o_hsl.hue, o_hsl.saturation, o_hsl.lightness);
            end else begin
                exp_res = expected_hsl.pop_front();
                if (o_hsl.hue !== exp_res.hue) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: hue mismatch expected %0d actual %0d", $time,
                                 exp_res.hue, o_hsl.hue);
                end
                if (o_hsl.saturation !== exp_res.saturation) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: saturation mismatch expected %0d actual %0d", $time,
                                 exp_res.saturation, o_hsl.saturation);
                end
                if (o_hsl.lightness !== exp_res.lightness) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: lightness mismatch expected %0d actual %0d", $time,
                                 exp_res.lightness, o_hsl.lightness);
                end
            end
        end
    end

    // watchdog on cycles with no transfer and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
        t_rgb px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        expected_hsl.push_back(hsl_of(px));
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_idle();
        int n;
        n = 0;
        while ($urandom_range(0, 99) < IDLE_PCT) n++;
        idle_cycles(n);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_hsl.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd254, 8'd0,   8'd100);
        send_pixel(8'd255, 8'd1,   8'd50);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd10,  8'd200, 8'd200);
        send_pixel(8'd200, 8'd10,  8'd200);
        send_pixel(8'd3,   8'd7,   8'd5);
        send_pixel(8'd250, 8'd251, 8'd252);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd0,   8'd1,   8'd255);
        idle_cycles(1);
    endtask

    // mix of uniform pixels and fully saturated hue sweeps, random idling
    task automatic test_random_idle(input int count);
        logic [CH_W-1:0] r, g, b, v;
        for (int i = 0; i < count; i++) begin
            r = CH_W'($urandom_range(0, 255));
            g = CH_W'($urandom_range(0, 255));
            b = CH_W'($urandom_range(0, 255));
            v = CH_W'($urandom_range(0, 255));
            case ($urandom_range(0, 5))
                0: send_pixel(8'd255, v, 8'd0);
                1: send_pixel(v, 8'd0, 8'd255);
                2: send_pixel(8'd0, 8'd255, v);
                default: send_pixel(r, g, b);
            endcase
            random_idle();
        end
    endtask

    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                       CH_W'($urandom_range(0, 255)));
        idle_cycles(1);
    endtask

    // small deltas around a random grey level, ties and grey pixels frequent
    task automatic test_near_grey(input int count);
        int base;
        for (int i = 0; i < count; i++) begin
            base = $urandom_range(3, 252);
            send_pixel(CH_W'(base - 3 + int'($urandom_range(0, 6))),
                       CH_W'(base - 3 + int'($urandom_range(0, 6))),
                       CH_W'(base - 3 + int'($urandom_range(0, 6))));
            random_idle();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_pixel      = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_random_idle(1000);
        wait_drained();
        test_back_to_back(400);
        test_near_grey(400);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- rgb_to_hsl_pixel.f -----
design/rhsl_pkg.sv
design/rhsl_front.sv
design/rhsl_queue.sv
design/rhsl_div_pipe.sv
design/rgb_to_hsl_pixel.sv
sim/tb_top.sv
